// File: sv/shb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the SHA-256 byte stream hasher.
// No dependencies; used by the controller, the datapath and the top level.
package shb_pkg;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [7:0]  PAD_BYTE  = 8'h80;
  localparam logic [5:0]  LAST_FILL = 6'd63;
  localparam logic [63:0] BLOCK_BITS = 64'd512;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_ADD,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_PAD80,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic      shift_en;     // push one byte into the block buffer
    byte_sel_t byte_sel;
    logic      start_cmp;    // load working vars from chain, clear round count
    logic      round_en;
    logic      chain_add;
    logic      len_add_blk;  // full block absorbed
    logic      len_add_tail; // finish: add the tail bytes
    logic      digest_load;
    logic      hash_init;
  } cmd_t;

  typedef struct packed {
    logic last_byte;   // buffer holds 63 bytes
    logic fill_hi;     // buffer holds 56 or more bytes
    logic round_last;
  } sts_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

// File: sv/shb_ctrl.sv
`timescale 1ns / 1ps
// Controller for the SHA-256 hasher: handshakes, padding sequence, round control.
// Depends on shb_pkg; drives shb_datapath through shb_pkg::cmd_t.
module shb_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_op,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  shb_pkg::sts_t  sts,
  output shb_pkg::cmd_t  cmd
);

  shb_pkg::state_t state_r, state_nxt;
  logic padding_r, padding_nxt;
  logic first_r, first_nxt;     // next pad byte is the 0x80 marker
  logic len_ok_r, len_ok_nxt;   // length field goes in this block
  logic out_valid_r, out_valid_nxt;
  logic in_acc;

  assign in_stall  = (state_r != shb_pkg::S_IDLE) ||
                     ((in_op == shb_pkg::OP_FINISH) && out_valid_r);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // next state and flags
  always_comb begin
    state_nxt     = state_r;
    padding_nxt   = padding_r;
    first_nxt     = first_r;
    len_ok_nxt    = len_ok_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      shb_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_op == shb_pkg::OP_FINISH) begin
            state_nxt   = shb_pkg::S_PAD;
            padding_nxt = 1'b1;
            first_nxt   = 1'b1;
            len_ok_nxt  = !sts.fill_hi;
          end else if (sts.last_byte) begin
            state_nxt = shb_pkg::S_ROUND;
          end
        end
      end
      shb_pkg::S_PAD: begin
        first_nxt = 1'b0;
        if (sts.last_byte) begin
          state_nxt = shb_pkg::S_ROUND;
        end
      end
      shb_pkg::S_ROUND: begin
        if (sts.round_last) begin
          state_nxt = shb_pkg::S_ADD;
        end
      end
      shb_pkg::S_ADD: begin
        if (!padding_r) begin
          state_nxt = shb_pkg::S_IDLE;
        end else if (len_ok_r) begin
          state_nxt = shb_pkg::S_DONE;
        end else begin
          // marker block done, length goes in a second block
          state_nxt  = shb_pkg::S_PAD;
          len_ok_nxt = 1'b1;
        end
      end
      shb_pkg::S_DONE: begin
        state_nxt     = shb_pkg::S_IDLE;
        padding_nxt   = 1'b0;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = shb_pkg::S_IDLE;
      end
    endcase
  end

  // datapath commands
  always_comb begin
    cmd = '0;
    cmd.byte_sel = shb_pkg::SEL_DATA;
    case (state_r)
      shb_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_op == shb_pkg::OP_FINISH) begin
            cmd.len_add_tail = 1'b1;
          end else begin
            cmd.shift_en    = 1'b1;
            cmd.start_cmp   = sts.last_byte;
            cmd.len_add_blk = sts.last_byte;
          end
        end
      end
      shb_pkg::S_PAD: begin
        cmd.shift_en  = 1'b1;
        cmd.start_cmp = sts.last_byte;
        if (first_r) begin
          cmd.byte_sel = shb_pkg::SEL_PAD80;
        end else if (len_ok_r && sts.fill_hi) begin
          cmd.byte_sel = shb_pkg::SEL_LEN;
        end else begin
          cmd.byte_sel = shb_pkg::SEL_ZERO;
        end
      end
      shb_pkg::S_ROUND: begin
        cmd.round_en = 1'b1;
      end
      shb_pkg::S_ADD: begin
        cmd.chain_add = 1'b1;
      end
      shb_pkg::S_DONE: begin
        cmd.digest_load = 1'b1;
        cmd.hash_init   = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= shb_pkg::S_IDLE;
      padding_r   <= 1'b0;
      first_r     <= 1'b0;
      len_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      padding_r   <= padding_nxt;
      first_r     <= first_nxt;
      len_ok_r    <= len_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: sv/shb_datapath.sv
`timescale 1ns / 1ps
// Datapath for the SHA-256 hasher: block buffer / schedule window, round unit,
// chaining words, bit length and digest register. Depends on shb_pkg.
module shb_datapath (
  input  logic           clk,
  input  logic           rst_n,
  input  shb_pkg::cmd_t  cmd,
  output shb_pkg::sts_t  sts,
  input  logic [7:0]     in_data_byte,
  output logic [63:0]    out_digest_w0,
  output logic [63:0]    out_digest_w1,
  output logic [63:0]    out_digest_w2,
  output logic [63:0]    out_digest_w3
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // Buffer is a 512-bit shift line; bytes and schedule words enter at the bottom,
  // so the oldest word (w[t] during round t) sits at the top.
  logic [511:0] buf_r, buf_nxt;
  logic [5:0]   fill_r;
  logic [63:0]  len_r;
  logic [31:0]  chain_r [8];
  logic [31:0]  v_r [8];
  logic [5:0]   rnd_r;
  logic [255:0] digest_r;

  logic [7:0]  byte_in;
  logic [2:0]  len_idx;
  logic [31:0] w0, w1, w9, w14, w_new;
  logic [31:0] s0, s1, big0, big1, choose, major, t1, t2;

  assign len_idx = 3'd7 - fill_r[2:0];

  always_comb begin
    case (cmd.byte_sel)
      shb_pkg::SEL_DATA:  byte_in = in_data_byte;
      shb_pkg::SEL_PAD80: byte_in = shb_pkg::PAD_BYTE;
      shb_pkg::SEL_LEN:   byte_in = len_r[{len_idx, 3'b000} +: 8];
      default:            byte_in = 8'h00;
    endcase
  end

  // message schedule
  assign w0    = buf_r[511:480];
  assign w1    = buf_r[479:448];
  assign w9    = buf_r[223:192];
  assign w14   = buf_r[63:32];
  assign s0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign s1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign w_new = s1 + w9 + s0 + w0;

  // round function
  assign big1   = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
  assign choose = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign t1     = v_r[7] + big1 + choose + shb_pkg::ROUND_K[rnd_r] + w0;
  assign big0   = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
  assign major  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t2     = big0 + major;

  always_comb begin
    buf_nxt = buf_r;
    if (cmd.shift_en) begin
      buf_nxt = {buf_r[503:0], byte_in};
    end else if (cmd.round_en) begin
      buf_nxt = {buf_r[479:0], w_new};
    end
  end

  assign sts.last_byte  = (fill_r == shb_pkg::LAST_FILL);
  assign sts.fill_hi    = (fill_r[5:3] == 3'b111);
  assign sts.round_last = (rnd_r == 6'd63);

  // buffer, working variables and digest carry no reset
  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    if (cmd.start_cmp) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= chain_r[i];
      end
    end else if (cmd.round_en) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
    if (cmd.digest_load) begin
      digest_r <= {chain_r[0], chain_r[1], chain_r[2], chain_r[3],
                   chain_r[4], chain_r[5], chain_r[6], chain_r[7]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      len_r  <= '0;
      rnd_r  <= '0;
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= shb_pkg::IV[i];
      end
    end else begin
      if (cmd.shift_en) begin
        fill_r <= fill_r + 6'd1;
      end
      if (cmd.start_cmp) begin
        rnd_r <= '0;
      end else if (cmd.round_en) begin
        rnd_r <= rnd_r + 6'd1;
      end
      if (cmd.len_add_blk) begin
        len_r <= len_r + shb_pkg::BLOCK_BITS;
      end else if (cmd.len_add_tail) begin
        len_r <= len_r + {55'd0, fill_r, 3'b000};
      end
      if (cmd.chain_add) begin
        for (int i = 0; i < 8; i++) begin
          chain_r[i] <= chain_r[i] + v_r[i];
        end
      end
      if (cmd.hash_init) begin
        fill_r <= '0;
        len_r  <= '0;
        for (int i = 0; i < 8; i++) begin
          chain_r[i] <= shb_pkg::IV[i];
        end
      end
    end
  end

  assign out_digest_w0 = digest_r[255:192];
  assign out_digest_w1 = digest_r[191:128];
  assign out_digest_w2 = digest_r[127:64];
  assign out_digest_w3 = digest_r[63:0];

endmodule

// File: sv/sha256_byte_stream_hasher.sv
`timescale 1ns / 1ps
// Channel   Ports                                      Direction
// input     in_valid, in_stall, in_op, in_data_byte    absorb byte or finish
// result    out_valid, out_stall, out_digest_w0..w3    256-bit digest, one per finish
//
// Absorb: one byte per cycle while no block or finish is in progress; the 64th byte
// of a block starts a compression (64 rounds on the single round unit, then the chaining add).
// Finish: pads with 64 - fill bytes (128 - fill with 56+ bytes buffered),
// compresses each padded block, then loads the digest.
// Synchronous active-low reset restores the initial hash; no clearing pass.
// A waiting digest does not stop absorb transactions; a finish waits for it.
// Top level: controller and datapath, depends on shb_pkg.
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_w0,
  output logic [63:0] out_digest_w1,
  output logic [63:0] out_digest_w2,
  output logic [63:0] out_digest_w3
);

  shb_pkg::cmd_t cmd;
  shb_pkg::sts_t sts;

  shb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  shb_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_data_byte  (in_data_byte),
    .out_digest_w0 (out_digest_w0),
    .out_digest_w1 (out_digest_w1),
    .out_digest_w2 (out_digest_w2),
    .out_digest_w3 (out_digest_w3)
  );

endmodule

// File: sv/shb_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the SHA-256 hasher, bound to the top level.
// Depends on shb_pkg and sha256_byte_stream_hasher.
module shb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_op,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_digest_w0
);

  // a stalled digest stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("digest withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_digest_w0))
    else $error("digest changed while stalled");

  // an absorb transaction never produces a digest
  a_absorb_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_op == shb_pkg::OP_ABSORB) |=> !$rose(out_valid))
    else $error("digest raised after absorb");

  // padding follows a finish, so input is held off
  a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_op == shb_pkg::OP_FINISH) |=> in_stall)
    else $error("input taken during padding");

endmodule

bind sha256_byte_stream_hasher shb_checker u_shb_checker (.*);
